// ===== src/multitap_echo_filter_core_assert.svh =====
// Assertion macros shared by the echo filter RTL.
// Each macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef MULTITAP_ECHO_FILTER_CORE_ASSERT_SVH
`define MULTITAP_ECHO_FILTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mec_pkg.sv =====
package mec_pkg;

    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 12;
    localparam int CNT_W      = 3;
    localparam int STEP_W     = 3;
    localparam int TAP_IDX_W  = 2;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 36;
    localparam int FRAC_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DELAYS_W   = 48;
    localparam int GAINS_W    = 64;

    localparam int BUF_DEPTH_DEF = 4096;
    localparam int MAX_TAPS_DEF  = 4;

    localparam logic signed [GAIN_W-1:0] INPUT_GAIN_RST = 16'sh7FFF;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_DELAYS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_GAINS  = 3'd3;

    // Sample operand source of one multiply step.
    localparam logic [1:0] SEL_CUR  = 2'd0;
    localparam logic [1:0] SEL_MEM  = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;

    typedef struct packed {
        logic              accept;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] n_taps;
        logic             out_busy;
    } t_dp_status;

endpackage

// ===== src/mec_ram.sv =====
module mec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mec_ctrl.sv =====
module mec_ctrl
    import mec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ISSUE  = 3'd1;
    localparam logic [2:0] S_DRAIN1 = 3'd2;
    localparam logic [2:0] S_DRAIN2 = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_step  = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.step  = r_step;
                if (r_step == STEP_W'(i_status.n_taps)) begin
                    n_state = S_DRAIN1;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_DONE;
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== src/mec_datapath.sv =====
module mec_datapath
    import mec_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    parameter int MAX_TAPS  = MAX_TAPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [DATA_W-1:0]     i_in_sample,
    input  logic                         i_out_ready,
    input  t_ctrl_cmd                    i_cmd,
    output t_dp_status                   o_status,
    output logic                         o_out_valid,
    output logic signed [DATA_W-1:0]     o_out_sample
);

    localparam int AW    = $clog2(BUF_DEPTH);
    localparam int EXT_W = (AW > DELAY_W) ? AW : DELAY_W;
    localparam int SH_W  = ACC_W - FRAC_W;

    // Configuration registers.
    logic signed [GAIN_W-1:0] r_input_gain;
    logic [CNT_W-1:0]         r_tap_count;
    logic [DELAYS_W-1:0]      r_tap_delays;
    logic [GAINS_W-1:0]       r_tap_gains;

    // Delay line state. r_full is set once every entry has been written.
    logic [AW-1:0]            r_wp;
    logic                     r_full;
    logic signed [DATA_W-1:0] r_x;

    // Issue stage.
    logic [TAP_IDX_W-1:0]     tap_idx;
    logic [DELAY_W-1:0]       tap_delay;
    logic [EXT_W-1:0]         addr_diff;
    logic [AW-1:0]            rd_addr;
    logic signed [GAIN_W-1:0] issue_gain;
    logic [1:0]               issue_sel;
    logic [DATA_W-1:0]        ram_rdata;

    // Multiply and accumulate stages.
    logic                     r_a_vld;
    logic signed [GAIN_W-1:0] r_a_gain;
    logic [1:0]               r_a_sel;
    logic signed [DATA_W-1:0] mul_sample;
    logic                     r_p_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // Output.
    logic signed [SH_W-1:0]   acc_sh;
    logic signed [DATA_W-1:0] sat_sample;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_sample;

    assign o_status.n_taps = (r_tap_count > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : r_tap_count;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_gain <= INPUT_GAIN_RST;
            r_tap_count  <= '0;
            r_tap_delays <= '0;
            r_tap_gains  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INPUT_GAIN: r_input_gain <= i_cfg_data[GAIN_W-1:0];
                REG_TAP_COUNT:  r_tap_count  <= i_cfg_data[CNT_W-1:0];
                REG_TAP_DELAYS: r_tap_delays <= i_cfg_data[DELAYS_W-1:0];
                REG_TAP_GAINS:  r_tap_gains  <= i_cfg_data[GAINS_W-1:0];
                default: ;
            endcase
        end
    end

    // Step zero is the input gain; step k reads tap k-1.
    assign tap_idx   = TAP_IDX_W'(i_cmd.step - 1'b1);
    assign tap_delay = r_tap_delays[tap_idx*DELAY_W +: DELAY_W];
    assign addr_diff = EXT_W'(r_wp) - EXT_W'(tap_delay);
    assign rd_addr   = addr_diff[AW-1:0];

    always_comb begin
        if (i_cmd.step == '0) begin
            issue_gain = r_input_gain;
            issue_sel  = SEL_CUR;
        end else begin
            issue_gain = r_tap_gains[tap_idx*GAIN_W +: GAIN_W];
            if (rd_addr == r_wp) begin
                issue_sel = SEL_CUR;
            end else if (!r_full && (rd_addr > r_wp)) begin
                issue_sel = SEL_ZERO;
            end else begin
                issue_sel = SEL_MEM;
            end
        end
    end

    mec_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_wp),
        .i_wdata (i_in_sample),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (r_a_sel)
            SEL_CUR:  mul_sample = r_x;
            SEL_MEM:  mul_sample = ram_rdata;
            default:  mul_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_p_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.issue;
            r_p_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_gain <= issue_gain;
        r_a_sel  <= issue_sel;
        r_prod   <= mul_sample * r_a_gain;
        if (i_cmd.accept) begin
            r_x   <= i_in_sample;
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Floor shift, then saturate when the upper bits are not a sign extension.
    assign acc_sh = SH_W'(r_acc >>> FRAC_W);

    always_comb begin
        if ((&acc_sh[SH_W-1:DATA_W-1]) || !(|acc_sh[SH_W-1:DATA_W-1])) begin
            sat_sample = acc_sh[DATA_W-1:0];
        end else if (acc_sh[SH_W-1]) begin
            sat_sample = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_sample = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_wp        <= r_wp + 1'b1;
                r_out_valid <= 1'b1;
                if (&r_wp) begin
                    r_full <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_sample <= sat_sample;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

endmodule

// ===== src/multitap_echo_filter_core.sv =====
// Channel   Handshake                  Payload
// --------  -------------------------  -----------------------------------
// input     i_in_valid / o_in_ready    i_in_sample  (signed 16 bit)
// output    o_out_valid / i_out_ready  o_out_sample (signed 16 bit)
// config    i_cfg_we (no wait)         i_cfg_index, i_cfg_data (64 bit)
//
// An input transaction keeps the core busy until its result is loaded: one delay RAM read
// port and one shared multiplier handle the input gain, then one tap a cycle for the tap
// count limited to MAX_TAPS, followed by the drain of the multiply pipeline.
// Reset is synchronous; a fill flag makes never-written RAM entries read as zero, so no
// clearing pass is needed. A finished result waits in the output register and does not
// block the next input; the core stalls only when a second result is done and the first waits.

module multitap_echo_filter_core
    import mec_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    parameter int MAX_TAPS  = MAX_TAPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_in_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_out_sample
);

    // Command and status between the sequencer and the datapath.
    t_ctrl_cmd  s_cmd;
    t_dp_status s_status;

    // The sequencer accepts a sample, issues the gain step and one step per tap,
    // waits for the multiply pipeline to drain and then loads the output register.
    mec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    // The datapath holds the configuration, the delay RAM with its write pointer,
    // the multiply-accumulate pipeline and the saturating output register.
    mec_datapath #(
        .BUF_DEPTH (BUF_DEPTH),
        .MAX_TAPS  (MAX_TAPS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_sample  (i_in_sample),
        .i_out_ready  (i_out_ready),
        .i_cmd        (s_cmd),
        .o_status     (s_status),
        .o_out_valid  (o_out_valid),
        .o_out_sample (o_out_sample)
    );

    `include "multitap_echo_filter_core_assert.svh"

    // A result is loaded only when the output register is free or being emptied.
    `MEC_ASSERT_SAME(a_load_no_overwrite, s_cmd.load_out, !o_out_valid || i_out_ready, "result lost")

    // Output valid rises only after the sequencer loaded a result.
    `MEC_ASSERT_SAME(a_out_from_load, $rose(o_out_valid), $past(s_cmd.load_out), "spurious result")

    // One sample is processed at a time: the core is busy right after an accept.
    `MEC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "accept while busy")

endmodule
